[hw/rtl/dmc_pkg.sv]
package dmc_pkg;

   localparam int CMD_W  = 2;
   localparam int ADDR_W = 32;
   localparam int WORD_W = 32;
   localparam int KIND_W = 3;
   localparam int SET_W  = 4;
   localparam int TAG_W  = 26;
   localparam int BYTE_W = 8;
   localparam int OFF_W  = 2;

   // address split: offset [1:0], set field [5:2], tag [31:6]
   localparam int SET_LSB = 2;
   localparam int TAG_LSB = 6;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [TAG_W-1:0]  tag_type;
   typedef logic [WORD_W-1:0] word_type;

   localparam cmd_type CMD_READ  = 2'd0;
   localparam cmd_type CMD_WRITE = 2'd1;
   localparam cmd_type CMD_LIST  = 2'd2;

   localparam kind_type KIND_EVICTED  = 3'd0;
   localparam kind_type KIND_WROTE    = 3'd1;
   localparam kind_type KIND_INVALID  = 3'd2;
   localparam kind_type KIND_HIT      = 3'd3;
   localparam kind_type KIND_MISMATCH = 3'd4;
   localparam kind_type KIND_LISTED   = 3'd5;

   // one block as held in the data memory
   typedef struct packed {
      tag_type  tag;
      word_type word;
   } block_type;

endpackage

[hw/rtl/direct_mapped_cache_model_unit.sv]
// Direct-mapped cache of one-word blocks, SETS sets.
// Request channel (req_valid / req_stall): cmd, 32-bit address, write word.
//   read  -> one word: invalid miss, hit or tag mismatch (stored tag + byte).
//   write -> evicted word first if the set was valid, then a wrote word.
//   list  -> one listed word per valid block in set order, last marked;
//            nothing at all when no block is valid.
// Response channel (rsp_valid / rsp_stall): kind, set, tag, word, byte, last.
// Blocks live in a single-port synchronous memory with a registered read;
// valid bits are flops. One request is in flight at a time.
// Steps after a request is accepted:
//   read  : lookup registers the response word once the output is free, then idle.
//   write : lookup, optional evict, write-back.
//   list  : a scan step per set, plus an emit step per valid block.
//   unused command 3: dropped, next request taken in the next cycle.
// The response register frees up the same cycle its word is taken, so a
// stalled receiver just holds the FSM in its emitting state; nothing is lost.
// Reset (synchronous, active high) clears all valid bits and the FSM at once;
// no clearing pass. Only the first min(SETS,16) sets are reachable, since the
// set is the 4-bit set field modulo SETS, so only those are stored.
module direct_mapped_cache_model_unit
   import dmc_pkg::*;
#(
   parameter int SETS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [WORD_W-1:0] req_write_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [SET_W-1:0]  rsp_set_index,
   output logic [TAG_W-1:0]  rsp_tag_out,
   output logic [WORD_W-1:0] rsp_word_out,
   output logic [BYTE_W-1:0] rsp_byte_out,
   output logic              rsp_last
);

   // sets the 4-bit field can reach
   localparam int DEPTH = (SETS < 16) ? SETS : 16;
   localparam int IW    = $clog2(DEPTH);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOOKUP = 3'd1;  // memory data valid
   localparam logic [2:0] ST_WRITE  = 3'd2;  // emit wrote, write back
   localparam logic [2:0] ST_SCAN   = 3'd3;  // list: find next valid set
   localparam logic [2:0] ST_LIST   = 3'd4;  // list: emit one block

   // set field modulo SETS (exact for SETS >= 2), at most eight subtractions on 4 bits
   function automatic logic [SET_W-1:0] set_of(input logic [SET_W-1:0] f);
      logic [SET_W-1:0] r;
      r = f;
      for (int k = 0; k < 8; k++) begin
         if (int'(r) >= SETS) begin
            r = r - SET_W'(SETS);
         end
      end
      return r;
   endfunction

   // state
   logic [2:0]        state_ff, state_in;
   logic [DEPTH-1:0]  valid_ff, valid_in;
   cmd_type           cmd_ff, cmd_in;
   logic [IW-1:0]     idx_ff, idx_in;
   tag_type           tag_ff, tag_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   word_type          wval_ff, wval_in;
   logic [IW-1:0]     ptr_ff, ptr_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [SET_W-1:0]  rsp_set_ff, rsp_set_in;
   tag_type           rsp_tag_ff, rsp_tag_in;
   word_type          rsp_word_ff, rsp_word_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   // block memory
   block_type         mem [DEPTH];
   block_type         rd_data_ff;
   logic              mem_rd_en;
   logic [IW-1:0]     mem_rd_addr;
   logic              mem_wr_en;

   logic              req_accept;
   logic              out_free;
   logic [SET_W-1:0]  req_set;
   logic              more_above;
   logic [BYTE_W-1:0] sel_byte;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_set    = set_of(req_address[SET_LSB +: SET_W]);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_set_index = rsp_set_ff;
   assign rsp_tag_out   = rsp_tag_ff;
   assign rsp_word_out  = rsp_word_ff;
   assign rsp_byte_out  = rsp_byte_ff;
   assign rsp_last      = rsp_last_ff;

   // any valid block past the list pointer
   always_comb begin
      more_above = 1'b0;
      for (int j = 0; j < DEPTH; j++) begin
         if (j > int'(ptr_ff) && valid_ff[j]) begin
            more_above = 1'b1;
         end
      end
   end

   // little-endian byte of the stored word
   always_comb begin
      unique case (off_ff)
         2'd0:    sel_byte = rd_data_ff.word[7:0];
         2'd1:    sel_byte = rd_data_ff.word[15:8];
         2'd2:    sel_byte = rd_data_ff.word[23:16];
         default: sel_byte = rd_data_ff.word[31:24];
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      tag_in      = tag_ff;
      off_in      = off_ff;
      wval_in     = wval_ff;
      ptr_in      = ptr_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff;
      mem_wr_en   = 1'b0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_set_in   = rsp_set_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            mem_rd_addr = req_set[IW-1:0];
            if (req_accept) begin
               cmd_in  = req_cmd;
               idx_in  = req_set[IW-1:0];
               tag_in  = req_address[TAG_LSB +: TAG_W];
               off_in  = req_address[OFF_W-1:0];
               wval_in = req_write_value;
               ptr_in  = '0;
               unique case (req_cmd)
                  CMD_READ, CMD_WRITE: begin
                     mem_rd_en = 1'b1;
                     state_in  = ST_LOOKUP;
                  end
                  CMD_LIST: state_in = ST_SCAN;
                  default:  state_in = ST_IDLE;  // unused command, dropped
               endcase
            end
         end

         ST_LOOKUP: begin
            if (cmd_ff == CMD_READ) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_set_in   = SET_W'(idx_ff);
                  rsp_word_in  = '0;
                  rsp_last_in  = 1'b1;
                  if (!valid_ff[idx_ff]) begin
                     rsp_kind_in = KIND_INVALID;
                     rsp_tag_in  = '0;
                     rsp_byte_in = '0;
                  end else begin
                     rsp_kind_in = (rd_data_ff.tag == tag_ff) ? KIND_HIT : KIND_MISMATCH;
                     rsp_tag_in  = rd_data_ff.tag;
                     rsp_byte_in = sel_byte;
                  end
                  state_in = ST_IDLE;
               end
            end else if (!valid_ff[idx_ff]) begin
               state_in = ST_WRITE;
            end else if (out_free) begin
               // old block goes out before the wrote word
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_EVICTED;
               rsp_set_in   = SET_W'(idx_ff);
               rsp_tag_in   = rd_data_ff.tag;
               rsp_word_in  = rd_data_ff.word;
               rsp_byte_in  = '0;
               rsp_last_in  = 1'b0;
               state_in     = ST_WRITE;
            end
         end

         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_kind_in      = KIND_WROTE;
               rsp_set_in       = SET_W'(idx_ff);
               rsp_tag_in       = tag_ff;
               rsp_word_in      = wval_ff;
               rsp_byte_in      = '0;
               rsp_last_in      = 1'b1;
               mem_wr_en        = 1'b1;
               valid_in[idx_ff] = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         ST_SCAN: begin
            if (valid_ff[ptr_ff]) begin
               mem_rd_en = 1'b1;
               state_in  = ST_LIST;
            end else if (int'(ptr_ff) == DEPTH - 1) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         ST_LIST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_LISTED;
               rsp_set_in   = SET_W'(ptr_ff);
               rsp_tag_in   = rd_data_ff.tag;
               rsp_word_in  = rd_data_ff.word;
               rsp_byte_in  = '0;
               rsp_last_in  = !more_above;
               if (more_above) begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      tag_ff      <= tag_in;
      off_ff      <= off_in;
      wval_ff     <= wval_in;
      ptr_ff      <= ptr_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_set_ff  <= rsp_set_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_word_ff <= rsp_word_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // single-port block memory; read and write never share a cycle
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[idx_ff] <= '{tag: tag_ff, word: wval_ff};
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
   import dmc_pkg::*;

   localparam int      NUM_SETS     = 16;
   localparam int      RANDOM_WORDS = 200;
   localparam int      LONG_HOLD    = 150;   // receiver hold-off, cycles
   localparam int      DRAIN_CYCLES = 60;    // covers a full list walk
   localparam cmd_type CMD_UNUSED   = 2'd3;

   // one word on the response channel, as the bench predicts it
   typedef struct {
      kind_type          kind;
      logic [SET_W-1:0]  set_idx;
      tag_type           tag;
      word_type          word;
      logic [BYTE_W-1:0] byte_val;
      logic              last;
   } cache_word_type;

   // Shadow copy of the cache plus the queue of words still owed by the unit.
   class cache_scoreboard;
      logic           valid_q[NUM_SETS];
      tag_type        tag_q[NUM_SETS];
      word_type       word_q[NUM_SETS];
      cache_word_type owed_q[$];
      int             errors;
      int             requests;
      int             kind_seen[6];

      function new();
         foreach (valid_q[i]) begin
            valid_q[i] = 1'b0;
            tag_q[i]   = '0;
            word_q[i]  = '0;
         end
         foreach (kind_seen[i]) kind_seen[i] = 0;
         errors   = 0;
         requests = 0;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void owe(kind_type k, logic [SET_W-1:0] s, tag_type t, word_type w,
                        logic [BYTE_W-1:0] b, logic l);
         cache_word_type e;
         e.kind = k; e.set_idx = s; e.tag = t; e.word = w; e.byte_val = b; e.last = l;
         owed_q.push_back(e);
      endfunction

      function void note_request(cmd_type cmd, logic [ADDR_W-1:0] addr, word_type wval);
         logic [SET_W-1:0]  s;
         tag_type           t;
         logic [OFF_W-1:0]  off;
         int                first;
         s   = SET_W'(addr[TAG_LSB-1:SET_LSB] % NUM_SETS);
         t   = addr[ADDR_W-1:TAG_LSB];
         off = addr[OFF_W-1:0];
         requests++;
         case (cmd)
            CMD_READ: begin
               if (!valid_q[s])
                  owe(KIND_INVALID, s, '0, '0, '0, 1'b1);
               else
                  owe((tag_q[s] == t) ? KIND_HIT : KIND_MISMATCH, s, tag_q[s], '0,
                      word_q[s][8*off +: 8], 1'b1);
            end
            CMD_WRITE: begin
               // old block goes out first, even on a matching tag
               if (valid_q[s]) owe(KIND_EVICTED, s, tag_q[s], word_q[s], '0, 1'b0);
               valid_q[s] = 1'b1;
               tag_q[s]   = t;
               word_q[s]  = wval;
               owe(KIND_WROTE, s, t, wval, '0, 1'b1);
            end
            CMD_LIST: begin
               first = owed_q.size();
               for (int i = 0; i < NUM_SETS; i++)
                  if (valid_q[i])
                     owe(KIND_LISTED, SET_W'(i), tag_q[i], word_q[i], '0, 1'b0);
               if (owed_q.size() > first) owed_q[owed_q.size()-1].last = 1'b1;
            end
            default: ;  // unused code: dropped
         endcase
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(cache_word_type got);
         cache_word_type e;
         if (owed_q.size() == 0) begin
            report($sformatf("unexpected word kind=%0d set=%0d", got.kind, got.set_idx));
         end else begin
            e = owed_q.pop_front();
            if (got.kind < 6) kind_seen[got.kind]++;
            if (got.kind !== e.kind || got.set_idx !== e.set_idx || got.tag !== e.tag ||
                got.word !== e.word || got.byte_val !== e.byte_val || got.last !== e.last)
               report($sformatf(
                  "got k%0d s%0d t%h w%h b%h l%0d, exp k%0d s%0d t%h w%h b%h l%0d",
                  got.kind, got.set_idx, got.tag, got.word, got.byte_val, got.last,
                  e.kind, e.set_idx, e.tag, e.word, e.byte_val, e.last));
         end
      endtask
   endclass

   // ---------------------------------------------------------------------
   // DUT signals
   // ---------------------------------------------------------------------
   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [CMD_W-1:0]  req_cmd;
   logic [ADDR_W-1:0] req_address;
   logic [WORD_W-1:0] req_write_value;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [KIND_W-1:0] rsp_kind;
   logic [SET_W-1:0]  rsp_set_index;
   logic [TAG_W-1:0]  rsp_tag_out;
   logic [WORD_W-1:0] rsp_word_out;
   logic [BYTE_W-1:0] rsp_byte_out;
   logic              rsp_last;

   cache_scoreboard sb = new();

   // quiet: no idle gaps on either side; long_hold_req: receiver holds off
   logic quiet;
   logic long_hold_req;

   direct_mapped_cache_model_unit #(
      .SETS(NUM_SETS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_address    (req_address),
      .req_write_value(req_write_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_set_index  (rsp_set_index),
      .rsp_tag_out    (rsp_tag_out),
      .rsp_word_out   (rsp_word_out),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop. Worst case is far below this: ~250 requests, each a full
   // 16-word list, every word at its longest stall, plus the long hold.
   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Monitors: everything is sampled at the rising edge, inputs only change
   // at the falling edge, so there is no ordering race with the DUT.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_cmd, req_address, req_write_value);
   end

   always @(posedge clock) begin
      cache_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind     = rsp_kind;
         got.set_idx  = rsp_set_index;
         got.tag      = rsp_tag_out;
         got.word     = rsp_word_out;
         got.byte_val = rsp_byte_out;
         got.last     = rsp_last;
         sb.check_result(got);
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: per word, stall at random (never when quiet), then take it. A long
   // hold-off request makes it sit on stall once so the unit backs up.
   // ---------------------------------------------------------------------
   initial begin
      int   wait_n;
      logic held;
      held      = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_req && !held) begin
            held      = 1'b1;
            rsp_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end
         wait_n = quiet ? 0 : $urandom_range(0, 10);
         for (int i = 0; i < wait_n; i++) begin
            rsp_stall = 1'b1;
            @(negedge clock);
         end
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   // Offer one word after a random gap and hold it until the unit takes it.
   // Returns at the accepting rising edge.
   task send_word(cmd_type cmd, logic [ADDR_W-1:0] addr, word_type wval);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 10);
      for (int i = 0; i < gap; i++) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_cmd         = cmd;
      req_address     = addr;
      req_write_value = wval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] make_addr(tag_type t, logic [SET_W-1:0] s,
                                                   logic [OFF_W-1:0] o);
      return {t, s, o};
   endfunction

   // Mostly tags that are resident or from a small pool, so reads hit and
   // writes evict often; the rest fully random.
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [SET_W-1:0] s;
      tag_type          t;
      int               sel;
      s   = SET_W'($urandom_range(0, NUM_SETS - 1));
      sel = $urandom_range(0, 9);
      if (sel < 5)
         t = sb.tag_q[s];
      else if (sel < 7)
         case ($urandom_range(0, 3))
            0:       t = '0;
            1:       t = '1;
            2:       t = 26'h1555555;
            default: t = 26'h2AAAAAA;
         endcase
      else
         t = TAG_W'($urandom);
      return make_addr(t, s, OFF_W'($urandom_range(0, 3)));
   endfunction

   function automatic word_type pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // directed: extremes, every command, each special case
   task run_directed();
      send_word(CMD_READ,   make_addr('0, 0, 0), '0);              // invalid miss
      send_word(CMD_LIST,   '0, '0);                              // empty list: silent
      send_word(CMD_UNUSED, '1, '1);                              // dropped
      send_word(CMD_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(CMD_READ,   32'hFFFF_FFFF, '0);                   // hit, top byte
      send_word(CMD_READ,   make_addr('1, 15, 0), '0);             // hit, low byte
      send_word(CMD_READ,   make_addr('0, 15, 1), '0);             // tag mismatch
      send_word(CMD_WRITE,  make_addr('1, 15, 0), 32'h8040_2010); // evict, same tag
      send_word(CMD_READ,   make_addr(26'd1, 15, 2), '0);          // mismatch, byte 2
      send_word(CMD_WRITE,  '0, '0);
      send_word(CMD_READ,   '0, '0);
      send_word(CMD_WRITE,  make_addr(26'h2AAAAAA, 5, 3), 32'h1234_5678);
      for (int o = 0; o < 4; o++)
         send_word(CMD_READ, make_addr(26'h2AAAAAA, 5, OFF_W'(o)), '0);
      send_word(CMD_LIST,   '0, '0);                              // three blocks
      send_word(CMD_WRITE,  make_addr(26'h1555555, 5, 0), 32'hA5A5_5A5A);
      send_word(CMD_READ,   make_addr('0, 7, 0), '0);
      send_word(CMD_UNUSED, '0, '0);
   endtask

   // main stimulus
   initial begin
      int      sent;
      int      pick;
      logic    did_hold;
      logic    did_pause;
      logic    did_sweep;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_READ;
      req_address     = '0;
      req_write_value = '0;
      quiet           = 1'b0;
      long_hold_req   = 1'b0;
      did_hold        = 1'b0;
      did_pause       = 1'b0;
      did_sweep       = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      run_directed();

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         // stretches with no idling at all on either side
         quiet = ((sent / 25) % 3) == 2;
         if (!did_hold && sent >= 60) begin
            // receiver sits on stall; keep offering so the unit backs up
            did_hold      = 1'b1;
            long_hold_req = 1'b1;
         end
         if (!did_pause && sent >= 120) begin
            // sender goes quiet until every owed word has come back
            did_pause = 1'b1;
            @(negedge clock);
            req_valid = 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end
         if (!did_sweep && sent >= 150) begin
            // fill every set, then a full 16-word list
            did_sweep = 1'b1;
            for (int s = 0; s < NUM_SETS; s++)
               send_word(CMD_WRITE,
                         make_addr(TAG_W'($urandom), SET_W'(s),
                                   OFF_W'($urandom_range(0, 3))),
                         pick_word());
            send_word(CMD_LIST, '0, '0);
            sent += NUM_SETS + 1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            send_word(CMD_UNUSED, $urandom, $urandom);   // noise, not counted
         end else if (pick < 15) begin
            send_word(CMD_LIST, $urandom, $urandom);
            sent++;
         end else if (pick < 55) begin
            send_word(CMD_WRITE, pick_address(), pick_word());
            sent++;
         end else begin
            send_word(CMD_READ, pick_address(), $urandom);
            sent++;
         end
      end
      @(negedge clock);
      req_valid = 1'b0;
      quiet     = 1'b0;

      // drain, then give the unit time to misbehave with stray words
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected words never arrived", sb.pending()));

      $display("Covered %0d requests: %0d invalid misses, %0d hits, %0d tag mismatches",
               sb.requests, sb.kind_seen[KIND_INVALID], sb.kind_seen[KIND_HIT],
               sb.kind_seen[KIND_MISMATCH]);
      $display("  %0d writes, %0d evictions, %0d listed blocks, %0d mismatches",
               sb.kind_seen[KIND_WROTE], sb.kind_seen[KIND_EVICTED],
               sb.kind_seen[KIND_LISTED], sb.errors);
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
hw/rtl/dmc_pkg.sv
hw/rtl/direct_mapped_cache_model_unit.sv
bench/tb.sv
